>>> rtl/core/rsn_pkg.sv
package rsn_pkg;

  localparam int unsigned CNT_W      = 9;
  localparam int unsigned MUL_W      = 38;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned HB_W       = 37;
  localparam int unsigned ROOT_W     = 37;
  localparam int unsigned RAD_W      = 2 * ROOT_W;
  localparam int unsigned REM_W      = ROOT_W + 3;
  localparam int unsigned T_W        = 39;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  localparam logic [1:0] CFG_SPHERE_COUNT = 2'd0;
  localparam logic [1:0] CFG_MAX_DISTANCE = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_TRACE = 1'b1;

  localparam logic [2:0] STEP_DOT_X = 3'd0;
  localparam logic [2:0] STEP_DOT_Y = 3'd1;
  localparam logic [2:0] STEP_DOT_Z = 3'd2;
  localparam logic [2:0] STEP_HB_SQ = 3'd3;
  localparam logic [2:0] STEP_R_SQ  = 3'd4;
  localparam logic [2:0] STEP_EX_SQ = 3'd5;
  localparam logic [2:0] STEP_EY_SQ = 3'd6;
  localparam logic [2:0] STEP_EZ_SQ = 3'd7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_ROOT,
    ST_PICK,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0]        r;
  } entry_t;

  typedef struct packed {
    logic       load_sph;
    logic       load_ray;
    logic       idx_inc;
    logic       rd_en;
    logic       diff;
    logic       mul;
    logic       acc;
    logic [2:0] step;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       pick;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic miss;
  } sts_t;

endpackage

>>> rtl/core/rsn_ctrl.sv
module rsn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          op_i,
  input  rsn_pkg::sts_t sts_i,
  output rsn_pkg::cmd_t cmd_o,
  output logic          busy_o,
  output logic          done_o
);

  rsn_pkg::state_e state_q, state_d;
  logic [2:0] step_q, step_d;
  logic [5:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rsn_pkg::ST_IDLE;
      step_q  <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.step = step_q;
    unique case (state_q)
      rsn_pkg::ST_IDLE: begin
        if (start_i) begin
          if (op_i == rsn_pkg::OP_TRACE) begin
            cmd_o.load_ray = 1'b1;
            state_d = sts_i.empty ? rsn_pkg::ST_DONE : rsn_pkg::ST_READ;
          end else begin
            cmd_o.load_sph = 1'b1;
          end
        end
      end
      rsn_pkg::ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d = rsn_pkg::ST_DIFF;
      end
      rsn_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        step_d = rsn_pkg::STEP_DOT_X;
        state_d = rsn_pkg::ST_MUL;
      end
      rsn_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = rsn_pkg::ST_ACC;
      end
      rsn_pkg::ST_ACC: begin
        cmd_o.acc = 1'b1;
        if (step_q == rsn_pkg::STEP_EZ_SQ) begin
          state_d = rsn_pkg::ST_CHECK;
        end else begin
          step_d = step_q + 3'd1;
          state_d = rsn_pkg::ST_MUL;
        end
      end
      rsn_pkg::ST_CHECK: begin
        if (sts_i.miss) begin
          state_d = rsn_pkg::ST_NEXT;
        end else begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d = '0;
          state_d = rsn_pkg::ST_ROOT;
        end
      end
      rsn_pkg::ST_ROOT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(rsn_pkg::SQRT_STEPS - 1)) begin
          state_d = rsn_pkg::ST_PICK;
        end
      end
      rsn_pkg::ST_PICK: begin
        cmd_o.pick = 1'b1;
        state_d = rsn_pkg::ST_NEXT;
      end
      rsn_pkg::ST_NEXT: begin
        if (sts_i.last) begin
          state_d = rsn_pkg::ST_DONE;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d = rsn_pkg::ST_READ;
        end
      end
      rsn_pkg::ST_DONE: begin
        state_d = rsn_pkg::ST_IDLE;
      end
      default: begin
        state_d = rsn_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != rsn_pkg::ST_IDLE);
  assign done_o = (state_q == rsn_pkg::ST_DONE);

  a_done_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o)
    else $error("result strobe not followed by idle");

  a_root_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rsn_pkg::ST_ROOT) |-> (cnt_q < 6'(rsn_pkg::SQRT_STEPS)))
    else $error("root iteration count overrun");

  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && op_i == rsn_pkg::OP_LOAD) |=> !busy_o)
    else $error("load transaction left idle");

endmodule

>>> rtl/core/rsn_dp.sv
module rsn_dp #(
  parameter int unsigned MAX_SPHERES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rsn_pkg::cmd_t      cmd_i,
  output rsn_pkg::sts_t      sts_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic [3:0]         sphere_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  input  logic [30:0]        radius_i,
  output logic               hit_o,
  output logic [3:0]         hit_index_o,
  output logic [30:0]        distance_o
);

  localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int unsigned CW = rsn_pkg::CNT_W;

  rsn_pkg::entry_t mem [MAX_SPHERES];
  rsn_pkg::entry_t rdata_q;

  logic [4:0]  count_q;
  logic [30:0] max_dist_q;

  logic signed [31:0] ox_q, oy_q, oz_q;
  logic signed [17:0] dx_q, dy_q, dz_q;
  logic [AW-1:0]      idx_q;

  logic signed [32:0] ex_q, ey_q, ez_q;
  logic signed [rsn_pkg::PROD_W-1:0] prod_q, acc_q, acc_sum;
  logic signed [rsn_pkg::HB_W-1:0]   hb_q;
  logic signed [rsn_pkg::MUL_W-1:0]  mul_a, mul_b;

  logic [rsn_pkg::RAD_W-1:0]  rad_q;
  logic [rsn_pkg::REM_W-1:0]  rem_q, rem_n, trial;
  logic [rsn_pkg::ROOT_W-1:0] root_q;

  logic signed [rsn_pkg::T_W-1:0] neg_hb, root_s, near_t, far_t, t_sel, best_s;
  logic          found_q;
  logic [AW-1:0] best_idx_q;
  logic [30:0]   best_t_q;

  logic [CW-1:0] n_lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      max_dist_q <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rsn_pkg::CFG_SPHERE_COUNT: count_q    <= cfg_data_i[4:0];
        rsn_pkg::CFG_MAX_DISTANCE: max_dist_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sph && (CW'(sphere_index_i) < CW'(MAX_SPHERES))) begin
      mem[AW'(sphere_index_i)] <= '{cx: pos_x_i, cy: pos_y_i, cz: pos_z_i, r: radius_i};
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[idx_q];
    end
  end

  assign n_lim = (CW'(count_q) < CW'(MAX_SPHERES)) ? CW'(count_q) : CW'(MAX_SPHERES);
  assign sts_o.empty = (n_lim == '0);
  assign sts_o.last  = ((CW'(idx_q) + CW'(1)) >= n_lim);
  assign sts_o.miss  = acc_q[rsn_pkg::PROD_W-1];

  always_comb begin
    case (cmd_i.step)
      rsn_pkg::STEP_DOT_X: begin mul_a = 38'(dx_q); mul_b = 38'(ex_q); end
      rsn_pkg::STEP_DOT_Y: begin mul_a = 38'(dy_q); mul_b = 38'(ey_q); end
      rsn_pkg::STEP_DOT_Z: begin mul_a = 38'(dz_q); mul_b = 38'(ez_q); end
      rsn_pkg::STEP_HB_SQ: begin mul_a = 38'(hb_q); mul_b = 38'(hb_q); end
      rsn_pkg::STEP_R_SQ: begin
        mul_a = $signed({7'b0, rdata_q.r});
        mul_b = $signed({7'b0, rdata_q.r});
      end
      rsn_pkg::STEP_EX_SQ: begin mul_a = 38'(ex_q); mul_b = 38'(ex_q); end
      rsn_pkg::STEP_EY_SQ: begin mul_a = 38'(ey_q); mul_b = 38'(ey_q); end
      default:             begin mul_a = 38'(ez_q); mul_b = 38'(ez_q); end
    endcase
  end

  always_comb begin
    if (cmd_i.step >= rsn_pkg::STEP_EX_SQ) begin
      acc_sum = acc_q - prod_q;
    end else begin
      acc_sum = acc_q + prod_q;
    end
  end

  assign rem_n = {rem_q[rsn_pkg::REM_W-3:0], rad_q[rsn_pkg::RAD_W-1 -: 2]};
  assign trial = rsn_pkg::REM_W'({root_q, 2'b01});

  assign neg_hb = -rsn_pkg::T_W'(hb_q);
  assign root_s = $signed({2'b0, root_q});
  assign near_t = neg_hb - root_s;
  assign far_t  = neg_hb + root_s;
  assign t_sel  = (near_t > 0) ? near_t : far_t;
  assign best_s = $signed({8'b0, best_t_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ray) begin
      ox_q <= pos_x_i;
      oy_q <= pos_y_i;
      oz_q <= pos_z_i;
      dx_q <= dir_x_i;
      dy_q <= dir_y_i;
      dz_q <= dir_z_i;
    end
    if (cmd_i.diff) begin
      ex_q  <= 33'(ox_q) - 33'(rdata_q.cx);
      ey_q  <= 33'(oy_q) - 33'(rdata_q.cy);
      ez_q  <= 33'(oz_q) - 33'(rdata_q.cz);
      acc_q <= '0;
    end
    if (cmd_i.mul) begin
      prod_q <= mul_a * mul_b;
    end
    if (cmd_i.acc) begin
      if (cmd_i.step == rsn_pkg::STEP_DOT_Z) begin
        hb_q  <= rsn_pkg::HB_W'(acc_sum >>> 16);
        acc_q <= '0;
      end else begin
        acc_q <= acc_sum;
      end
    end
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_q[rsn_pkg::RAD_W-1:0];
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[rsn_pkg::RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[rsn_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[rsn_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.load_ray) begin
      idx_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + AW'(1);
      end
      if (cmd_i.pick && (t_sel > 0) && (t_sel < best_s)) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_ray) begin
      best_t_q   <= max_dist_q;
      best_idx_q <= '0;
    end else if (cmd_i.pick && (t_sel > 0) && (t_sel < best_s)) begin
      best_t_q   <= t_sel[30:0];
      best_idx_q <= idx_q;
    end
  end

  assign hit_o       = found_q;
  assign hit_index_o = found_q ? 4'(best_idx_q) : 4'd0;
  assign distance_o  = found_q ? best_t_q : 31'd0;

endmodule

>>> rtl/core/ray_sphere_nearest_hit.sv
// Channel   Signals                                   Transaction
// command   start_i, busy_o, op_i ... radius_i        start_i high while busy_o low
// config    cfg_valid_i, cfg_ready_o, index, data     cfg_valid_i and cfg_ready_o high
// result    done_o, hit_o, hit_index_o, distance_o    done_o high for one cycle
//
// A load writes one table entry and gives no result. A trace loads the ray, then for
// each sphere reads the entry, forms differences, runs the multiply-accumulate sequence
// and, unless missed, the bit-serial square root. Reset clears control and the sphere
// count and sets the maximum distance to all ones; table entries are undefined until
// loaded. The result cannot be stalled; the config port is always ready.
module ray_sphere_nearest_hit #(
  parameter int unsigned MAX_SPHERES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               op_i,
  input  logic [3:0]         sphere_index_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [17:0] dir_x_i,
  input  logic signed [17:0] dir_y_i,
  input  logic signed [17:0] dir_z_i,
  input  logic [30:0]        radius_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic               done_o,
  output logic               hit_o,
  output logic [3:0]         hit_index_o,
  output logic [30:0]        distance_o
);

  rsn_pkg::cmd_t cmd;
  rsn_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  rsn_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .op_i    (op_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  rsn_dp #(
    .MAX_SPHERES(MAX_SPHERES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .sphere_index_i (sphere_index_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .dir_x_i        (dir_x_i),
    .dir_y_i        (dir_y_i),
    .dir_z_i        (dir_z_i),
    .radius_i       (radius_i),
    .hit_o          (hit_o),
    .hit_index_o    (hit_index_o),
    .distance_o     (distance_o)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  typedef struct {
    logic        hit;
    logic [3:0]  idx;
    logic [30:0] distance;
  } hit_rec_t;

  typedef struct {
    longint cx, cy, cz;
    longint r;
  } sphere_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic               op_i = rsn_pkg::OP_LOAD;
  logic [3:0]         sphere_index_i = '0;
  logic signed [31:0] pos_x_i = '0;
  logic signed [31:0] pos_y_i = '0;
  logic signed [31:0] pos_z_i = '0;
  logic signed [17:0] dir_x_i = '0;
  logic signed [17:0] dir_y_i = '0;
  logic signed [17:0] dir_z_i = '0;
  logic [30:0]        radius_i = '0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               done_o;
  logic               hit_o;
  logic [3:0]         hit_index_o;
  logic [30:0]        distance_o;

  ray_sphere_nearest_hit dut (.*);

  localparam longint UNIT = 65536;
  localparam longint CYCLE_LIMIT = 8000000;

  sphere_t  spheres [16];
  int       count_cfg = 0;
  longint   max_dist_cfg = 64'd2147483647;
  hit_rec_t pending_hits [$];
  int       idle_pct = 0;
  int       errors = 0;
  int       traces = 0;
  int       hits_seen = 0;
  int       loads = 0;
  longint   cycles = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint isqrt(logic signed [127:0] v);
    logic [127:0] res;
    logic [127:0] cand;
    res = '0;
    for (int b = 40; b >= 0; b--) begin
      cand = res | (128'd1 << b);
      if ($signed(cand * cand) <= v) res = cand;
    end
    return longint'(res);
  endfunction

  function automatic hit_rec_t nearest_hit(longint px, longint py, longint pz,
                                           longint dx, longint dy, longint dz);
    hit_rec_t res;
    longint best, ex, ey, ez, hb, root, t;
    logic signed [127:0] pos_w, dd_w;
    int n;
    res = '{1'b0, 4'd0, 31'd0};
    best = max_dist_cfg;
    n = count_cfg > 16 ? 16 : count_cfg;
    for (int i = 0; i < n; i++) begin
      ex = px - spheres[i].cx;
      ey = py - spheres[i].cy;
      ez = pz - spheres[i].cz;
      hb = (dx * ex + dy * ey + dz * ez) >>> 16;
      pos_w = 128'(hb) * 128'(hb) + 128'(spheres[i].r) * 128'(spheres[i].r);
      dd_w = 128'(ex) * 128'(ex) + 128'(ey) * 128'(ey) + 128'(ez) * 128'(ez);
      if (dd_w > pos_w) continue;
      root = isqrt(pos_w - dd_w);
      t = -hb - root;
      if (t <= 0) t = -hb + root;
      if (t > 0 && t < best) begin
        best = t;
        res = '{1'b1, 4'(i), 31'(t)};
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    hit_rec_t want;
    if (rst_ni && done_o) begin
      if (pending_hits.size() == 0) begin
        $error("unexpected result: hit %0d index %0d distance %0d",
               hit_o, hit_index_o, distance_o);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (want.hit) hits_seen++;
        if (hit_o !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, hit_o);
          errors++;
        end
        if (hit_index_o !== want.idx) begin
          $error("hit_index: expected %0d, actual %0d", want.idx, hit_index_o);
          errors++;
        end
        if (distance_o !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, distance_o);
          errors++;
        end
      end
    end
  end

  task automatic send_item(logic op, logic [3:0] idx, longint px, longint py, longint pz,
                           longint dx, longint dy, longint dz, longint rad);
    logic signed [31:0] sx, sy, sz;
    logic signed [17:0] qx, qy, qz;
    logic [30:0] sr;
    sx = 32'(px); sy = 32'(py); sz = 32'(pz);
    qx = 18'(dx); qy = 18'(dy); qz = 18'(dz);
    sr = 31'(rad);
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    sphere_index_i <= idx;
    pos_x_i <= sx; pos_y_i <= sy; pos_z_i <= sz;
    dir_x_i <= qx; dir_y_i <= qy; dir_z_i <= qz;
    radius_i <= sr;
    do @(posedge clk_i); while (busy_o);
    if (op == rsn_pkg::OP_LOAD) begin
      spheres[idx] = '{longint'(sx), longint'(sy), longint'(sz), longint'(sr)};
      loads++;
    end else begin
      pending_hits.push_back(nearest_hit(sx, sy, sz, qx, qy, qz));
      traces++;
    end
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending_hits.size() != 0 || busy_o);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == rsn_pkg::CFG_SPHERE_COUNT) count_cfg = int'(data[4:0]);
    else if (idx == rsn_pkg::CFG_MAX_DISTANCE) max_dist_cfg = longint'(data[30:0]);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic trace(longint px, longint py, longint pz,
                       longint dx, longint dy, longint dz);
    send_item(rsn_pkg::OP_TRACE, 4'($urandom), px, py, pz, dx, dy, dz,
              longint'($urandom));
  endtask

  task automatic load(int idx, longint cx, longint cy, longint cz, longint rad);
    send_item(rsn_pkg::OP_LOAD, 4'(idx), cx, cy, cz, longint'($urandom),
              longint'($urandom), longint'($urandom), rad);
  endtask

  // unit direction from origin toward a target, with some jitter
  task automatic aim_trace(longint px, longint py, longint pz,
                           longint tx, longint ty, longint tz);
    real vx, vy, vz, n;
    vx = real'(tx - px) + real'($urandom_range(0, 2 * UNIT)) - UNIT;
    vy = real'(ty - py) + real'($urandom_range(0, 2 * UNIT)) - UNIT;
    vz = real'(tz - pz) + real'($urandom_range(0, 2 * UNIT)) - UNIT;
    n = $sqrt(vx * vx + vy * vy + vz * vz);
    if (n < 1.0) begin
      vx = 1.0; n = 1.0;
    end
    trace(px, py, pz, $rtoi(vx / n * 65536.0), $rtoi(vy / n * 65536.0),
          $rtoi(vz / n * 65536.0));
  endtask

  task automatic test_fill_table();
    write_reg(rsn_pkg::CFG_SPHERE_COUNT, 32'd0);
    trace(0, 0, 0, UNIT, 0, 0);
    for (int i = 0; i < 16; i++)
      load(i, (i - 8) * 4 * UNIT, i * UNIT, -i * UNIT, (i + 1) * UNIT / 2);
    wait_idle();
  endtask

  task automatic test_directed();
    write_reg(rsn_pkg::CFG_SPHERE_COUNT, 32'd16);
    write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'h7fff_ffff);
    load(0, 0, 0, 0, 2 * UNIT);
    load(1, 0, 0, 0, 2 * UNIT);
    trace(-10 * UNIT, 0, 0, UNIT, 0, 0);
    trace(0, UNIT / 2, 0, UNIT, 0, 0);
    trace(10 * UNIT, 0, 0, UNIT, 0, 0);
    trace(-10 * UNIT, 50 * UNIT, 0, UNIT, 0, 0);
    trace(-10 * UNIT, 0, 0, 131071, -131072, 0);
    trace(-32'sh8000_0000, 32'sh7fff_ffff, -32'sh8000_0000, -UNIT, UNIT, -UNIT);
    trace(32'sh7fff_ffff, -32'sh8000_0000, 32'sh7fff_ffff, 0, 0, -UNIT);
    load(2, 32'sh7fff_ffff, -32'sh8000_0000, 0, 31'h7fff_ffff);
    trace(0, 0, 0, 0, -UNIT, 0);
    trace(0, 0, 0, 0, 0, 0);
    wait_idle();
    write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'(5 * UNIT));
    trace(-10 * UNIT, 0, 0, UNIT, 0, 0);
    trace(-6 * UNIT, 0, 0, UNIT, 0, 0);
    wait_idle();
    write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'd0);
    trace(-10 * UNIT, 0, 0, UNIT, 0, 0);
    wait_idle();
    write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'd1);
    write_reg(rsn_pkg::CFG_SPHERE_COUNT, 32'hffff_ffff);
    write_reg(2'd2, 32'd3);
    write_reg(2'd3, 32'd0);
    trace(0, 0, 0, UNIT, 0, 0);
    wait_idle();
    write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'hffff_ffff);
    trace(-10 * UNIT, 0, 0, UNIT, 0, 0);
    wait_idle();
  endtask

  task automatic test_random(int pct, int n_items);
    int k;
    idle_pct = pct;
    k = 0;
    while (k < n_items) begin
      wait_idle();
      write_reg(rsn_pkg::CFG_SPHERE_COUNT,
                $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 5));
      case ($urandom_range(0, 3))
        0: write_reg(rsn_pkg::CFG_MAX_DISTANCE, $urandom);
        1: write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'($urandom_range(1, 60) * UNIT));
        default: write_reg(rsn_pkg::CFG_MAX_DISTANCE, 32'h7fff_ffff);
      endcase
      for (int j = 0; j < 40 && k < n_items; j++, k++) begin
        int s;
        s = $urandom_range(0, count_cfg > 16 ? 15 : (count_cfg == 0 ? 0 : count_cfg - 1));
        case ($urandom_range(0, 9))
          0: load($urandom_range(0, 15), longint'($urandom), longint'($urandom),
                  longint'($urandom), longint'($urandom));
          1, 2: load($urandom_range(0, 15),
                     $urandom_range(0, 40 * UNIT) - 20 * UNIT,
                     $urandom_range(0, 40 * UNIT) - 20 * UNIT,
                     $urandom_range(0, 40 * UNIT) - 20 * UNIT,
                     longint'($urandom_range(UNIT / 4, 8 * UNIT)));
          3: trace(longint'($urandom), longint'($urandom), longint'($urandom),
                   longint'($urandom), longint'($urandom), longint'($urandom));
          default: aim_trace($urandom_range(0, 80 * UNIT) - 40 * UNIT,
                             $urandom_range(0, 80 * UNIT) - 40 * UNIT,
                             $urandom_range(0, 80 * UNIT) - 40 * UNIT,
                             spheres[s].cx, spheres[s].cy, spheres[s].cz);
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_fill_table();
    test_directed();
    test_random(34, 500);
    test_random(74, 500);
    test_random(0, 500);
    $display("Ran %0d loads and %0d traces, %0d of them hits, over %0d cycles.",
             loads, traces, hits_seen, cycles);
    $display("Covered register extremes, ties, inside-sphere rays and range cut-offs.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
